>>> rtl/pcpfl_pkg.sv
// shared types and codes for the per-cpu page free list allocator
package pcpfl_pkg;

  localparam int ADDR_W = 32;

  // request codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_BAD   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MEMORY_BASE = 2'd0;
  localparam logic [1:0] REG_KERNEL_END  = 2'd1;
  localparam logic [1:0] REG_MEMORY_TOP  = 2'd2;

  // output of the shared add/subtract unit
  typedef struct packed {
    logic              carry;
    logic [ADDR_W-1:0] value;
  } sum_t;

endpackage

>>> rtl/per_cpu_page_free_list_allocator.sv
// per-cpu lifo page free lists with stealing, linked through a next-link ram
// free: three range checks and the page offset go through one shared 32-bit
//   add/subtract unit in states KEND, TOP and BASE, then the push
// allocate: one list head is examined per cycle in SCAN, then LINK takes
//   the next-link ram read and does the address add
// one transaction at a time; busy is high while it runs, results cannot be stalled
// reset empties every list and loads the default registers; the link ram is not cleared
module per_cpu_page_free_list_allocator
  import pcpfl_pkg::*;
#(
  parameter int CPU_COUNT  = 8,
  parameter int PAGE_COUNT = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              cmd,
  input  logic [2:0]        cpu_id,
  input  logic [ADDR_W-1:0] page_address,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [ADDR_W-1:0] wr_data,
  output logic              done,
  output logic [ADDR_W-1:0] granted_address,
  output logic [1:0]        status,
  output logic [2:0]        source_cpu
);

  localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int SCAN_W = CPU_W + 1;
  localparam int IDX_W  = $clog2(PAGE_COUNT);
  localparam int LINK_W = IDX_W + 1;
  localparam int SH     = $clog2(PAGE_BYTES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_LINK  = 3'd2;
  localparam logic [2:0] S_KEND  = 3'd3;
  localparam logic [2:0] S_TOP   = 3'd4;
  localparam logic [2:0] S_BASE  = 3'd5;
  localparam logic [2:0] S_PUSH  = 3'd6;

  logic [2:0]        state;
  logic [ADDR_W-1:0] memory_base;
  logic [ADDR_W-1:0] kernel_end;
  logic [ADDR_W-1:0] memory_top;
  logic [LINK_W-1:0] heads [CPU_COUNT];

  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] off;
  logic [CPU_W-1:0]  own;
  logic [SCAN_W-1:0] scan;
  logic              first;
  logic              bad;
  logic [IDX_W-1:0]  page;

  // shared add/subtract unit
  logic [ADDR_W-1:0] op_a;
  logic [ADDR_W-1:0] op_b;
  logic              op_sub;
  sum_t              sum;

  logic [LINK_W-1:0] head_sel;
  logic [SCAN_W-1:0] cand_base;
  logic [SCAN_W-1:0] cand;
  logic [CPU_W-1:0]  cpu_mod;
  logic [63:0]       page_off;
  logic [ADDR_W:0]   off_idx;
  logic              off_bad;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic [LINK_W-1:0] ram_rdata;

  // cpu number reduced modulo the cpu count by repeated subtraction
  function automatic logic [CPU_W-1:0] reduce_cpu(input logic [2:0] id);
    logic [4:0] v;
    v = {2'b00, id};
    for (int k = 0; k < 8; k++) begin
      if (v >= 5'(CPU_COUNT)) begin
        v = v - 5'(CPU_COUNT);
      end
    end
    return v[CPU_W-1:0];
  endfunction

  assign cpu_mod  = reduce_cpu(cpu_id);
  assign busy     = (state != S_IDLE);
  assign head_sel = heads[scan[CPU_W-1:0]];
  assign page_off = 64'(page) << SH;
  assign off_idx  = {1'b0, off} >> SH;
  assign off_bad  = (off[SH-1:0] != '0) || (off_idx >= (ADDR_W+1)'(PAGE_COUNT));

  assign cand_base = first ? '0 : scan + 1'b1;
  assign cand      = (cand_base == {1'b0, own}) ? cand_base + 1'b1 : cand_base;

  always_comb begin
    op_a   = addr;
    op_b   = kernel_end;
    op_sub = 1'b1;
    unique case (state)
      S_TOP:   op_b = memory_top;
      S_BASE:  op_b = memory_base;
      S_LINK: begin
        op_a   = memory_base;
        op_b   = page_off[ADDR_W-1:0];
        op_sub = 1'b0;
      end
      default: op_b = kernel_end;
    endcase
    sum = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + (ADDR_W+1)'(op_sub);
  end

  assign ram_we    = (state == S_PUSH) && !bad && !off_bad;
  assign ram_waddr = off_idx[IDX_W-1:0];
  assign ram_wdata = head_sel;

  pcpfl_ram #(
    .WIDTH(LINK_W),
    .DEPTH(PAGE_COUNT)
  ) u_links (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(head_sel[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      memory_base <= 32'h8000_0000;
      kernel_end  <= 32'h8000_0000;
      memory_top  <= 32'h8800_0000;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MEMORY_BASE: memory_base <= wr_data;
        REG_KERNEL_END:  kernel_end  <= wr_data;
        REG_MEMORY_TOP:  memory_top  <= wr_data;
        default: ;
      endcase
    end
  end

  // transaction payload, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        addr  <= page_address;
        own   <= cpu_mod;
        scan  <= {1'b0, cpu_mod};
        first <= 1'b1;
        bad   <= 1'b0;
      end
      S_SCAN: begin
        page <= head_sel[IDX_W-1:0];
        if (!head_sel[LINK_W-1]) begin
          scan  <= cand;
          first <= 1'b0;
        end
      end
      S_KEND:  bad <= bad | !sum.carry | (addr[SH-1:0] != '0);
      S_TOP:   bad <= bad | sum.carry;
      S_BASE: begin
        bad <= bad | !sum.carry;
        off <= sum.value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      for (int c = 0; c < CPU_COUNT; c++) begin
        heads[c] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= (cmd == CMD_FREE) ? S_KEND : S_SCAN;
          end
        end
        S_SCAN: begin
          if (head_sel[LINK_W-1]) begin
            state <= S_LINK;
          end else if (cand >= SCAN_W'(CPU_COUNT)) begin
            state           <= S_IDLE;
            done            <= 1'b1;
            granted_address <= '0;
            status          <= STATUS_EMPTY;
            source_cpu      <= '0;
          end
        end
        S_LINK: begin
          // head takes the next link of the popped page
          heads[scan[CPU_W-1:0]] <= ram_rdata;
          state                  <= S_IDLE;
          done                   <= 1'b1;
          granted_address        <= sum.value;
          status                 <= STATUS_OK;
          source_cpu             <= 3'(scan[CPU_W-1:0]);
        end
        S_KEND: state <= S_TOP;
        S_TOP:  state <= S_BASE;
        S_BASE: state <= S_PUSH;
        S_PUSH: begin
          state           <= S_IDLE;
          done            <= 1'b1;
          granted_address <= '0;
          source_cpu      <= '0;
          if (bad || off_bad) begin
            status <= STATUS_BAD;
          end else begin
            heads[scan[CPU_W-1:0]] <= {1'b1, off_idx[IDX_W-1:0]};
            status                 <= STATUS_OK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/pcpfl_ram.sv
// generic single write port, single read port ram with registered read
module pcpfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> dv/page_grant_checker.sv
// checker for the page allocator: mirrors the free lists and compares every result
`timescale 1ns / 1ps

module page_grant_checker
  import pcpfl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic              cmd,
  input  logic [2:0]        cpu_id,
  input  logic [ADDR_W-1:0] page_address,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [ADDR_W-1:0] wr_data,
  input  logic              done,
  input  logic [ADDR_W-1:0] granted_address,
  input  logic [1:0]        status,
  input  logic [2:0]        source_cpu,
  output int                fail_count,
  output int                open_count
);

  localparam int CPU_COUNT  = 8;
  localparam int PAGE_COUNT = 32768;
  localparam int PAGE_SHIFT = 12;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status;
    logic [2:0]        src;
  } grant_t;

  // list head and next link: bit 15 marks a valid link, bits 14:0 the page index
  logic [15:0]       list_head [CPU_COUNT];
  logic [15:0]       next_link [PAGE_COUNT];
  logic [ADDR_W-1:0] mem_base, kern_end, mem_top;
  grant_t            grant_q [$];
  int                shown;

  function automatic bit pop_page(int c, output logic [14:0] page);
    page = '0;
    if (!list_head[c][15]) return 1'b0;
    page = list_head[c][14:0];
    list_head[c] = next_link[page];
    return 1'b1;
  endfunction

  function automatic grant_t predict_grant(logic op, logic [2:0] who, logic [ADDR_W-1:0] a);
    grant_t            res;
    logic [ADDR_W-1:0] off;
    logic [14:0]       page;
    bit                got;
    int                i;
    res = '0;
    if (op == CMD_FREE) begin
      off = a - mem_base;
      if (a[PAGE_SHIFT-1:0] != '0 || a < kern_end || a >= mem_top || a < mem_base ||
          off[PAGE_SHIFT-1:0] != '0 || off[ADDR_W-1:PAGE_SHIFT] >= PAGE_COUNT) begin
        res.status = STATUS_BAD;
      end else begin
        next_link[off[26:12]] = list_head[who];
        list_head[who] = {1'b1, off[26:12]};
        res.status = STATUS_OK;
      end
    end else begin
      // own list first, then steal from the lowest numbered non-empty list
      got = pop_page(who, page);
      res.src = who;
      for (i = 0; i < CPU_COUNT && !got; i++) begin
        if (i != who && pop_page(i, page)) begin
          got = 1'b1;
          res.src = i[2:0];
        end
      end
      if (got) begin
        res.addr   = mem_base + ({17'b0, page} << PAGE_SHIFT);
        res.status = STATUS_OK;
      end else begin
        res.status = STATUS_EMPTY;
        res.src    = '0;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    int     c;
    if (rst) begin
      for (c = 0; c < CPU_COUNT; c++) list_head[c] = '0;
      mem_base = 32'h8000_0000;
      kern_end = 32'h8000_0000;
      mem_top  = 32'h8800_0000;
      grant_q.delete();
      shown = 0;
      fail_count <= 0;
      open_count <= 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_MEMORY_BASE: mem_base = wr_data;
          REG_KERNEL_END:  kern_end = wr_data;
          REG_MEMORY_TOP:  mem_top  = wr_data;
          default: ;
        endcase
      end
      if (done) begin
        if (grant_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (shown < 10) begin
            $display("unexpected transaction: addr %h status %0d src %0d",
                     granted_address, status, source_cpu);
          end
          shown++;
        end else begin
          want = grant_q.pop_front();
          if (granted_address !== want.addr || status !== want.status ||
              source_cpu !== want.src) begin
            fail_count <= fail_count + 1;
            if (shown < 10) begin
              $display("mismatch: expected addr %h status %0d src %0d, got addr %h status %0d src %0d",
                       want.addr, want.status, want.src, granted_address, status, source_cpu);
            end
            shown++;
          end
        end
      end
      if (start && !busy) grant_q.push_back(predict_grant(cmd, cpu_id, page_address));
      open_count <= grant_q.size();
    end
  end

endmodule

>>> dv/per_cpu_page_free_list_allocator_test.sv
// top of the page allocator testbench: stimulus, memory layouts and verdict
`timescale 1ns / 1ps

module per_cpu_page_free_list_allocator_test;
  import pcpfl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 12;

  logic              clk, rst;
  logic              start, busy, cmd, wr_en, done;
  logic [2:0]        cpu_id, source_cpu;
  logic [ADDR_W-1:0] page_address, wr_data, granted_address;
  logic [1:0]        wr_index, status;
  int                fails, open_items;
  int                cycles = 0;

  // stimulus-side copy of the layout, used to aim frees at real pages
  logic [ADDR_W-1:0] cur_base = 32'h8000_0000;
  logic [ADDR_W-1:0] cur_kend = 32'h8000_0000;
  logic [ADDR_W-1:0] cur_top  = 32'h8800_0000;
  logic [ADDR_W-1:0] last_free = 32'h8000_0000;
  int                fresh = 0;

  per_cpu_page_free_list_allocator u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .cpu_id(cpu_id),
    .page_address(page_address), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .granted_address(granted_address), .status(status), .source_cpu(source_cpu)
  );

  page_grant_checker u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .cpu_id(cpu_id),
    .page_address(page_address), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .granted_address(granted_address), .status(status), .source_cpu(source_cpu),
    .fail_count(fails), .open_count(open_items)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic issue_request(logic op, logic [2:0] who, logic [ADDR_W-1:0] a, bit steady);
    int gap;
    start        <= 1'b1;
    cmd          <= op;
    cpu_id       <= who;
    page_address <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (open_items != 0 || busy) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic load_layout(logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] k, logic [ADDR_W-1:0] t);
    wait_drained();
    wr_en    <= 1'b1;
    wr_index <= REG_MEMORY_BASE;
    wr_data  <= b;
    @(posedge clk);
    wr_index <= REG_KERNEL_END;
    wr_data  <= k;
    @(posedge clk);
    wr_index <= REG_MEMORY_TOP;
    wr_data  <= t;
    @(posedge clk);
    wr_en    <= 1'b0;
    cur_base = b;
    cur_kend = k;
    cur_top  = t;
  endtask

  // allocations and frees, the frees mostly of pages not yet listed, spread over a window of page indexes
  task automatic run_phase(int n, int lo, int win, bit allow_double);
    int                k, r, free_pct;
    bit                steady;
    logic [2:0]        who;
    logic [ADDR_W-1:0] pg, good, a;
    free_pct = 50;
    steady   = 1'b0;
    for (k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       free_pct = 25;
          1:       free_pct = 50;
          default: free_pct = 75;
        endcase
        steady = ($urandom_range(0, 3) == 0);
      end
      if (k == n / 2) wait_drained();
      who = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < free_pct) begin
        pg   = lo + fresh % win;
        good = cur_base + (pg << 12);
        r    = $urandom_range(0, 99);
        if (r < 85) begin
          a = good;
          last_free = good;
          fresh += $urandom_range(1, 3);
        end else if (r < 90) begin
          a = good ^ $urandom_range(1, 4095);
        end else if (r < 94) begin
          a = $urandom;
        end else if (r < 97) begin
          // page aligned but possibly not on a page of a misaligned base
          a = {good[31:12], 12'h000};
          fresh += $urandom_range(1, 3);
        end else if (r < 99) begin
          case ($urandom_range(0, 2))
            0:       a = (cur_kend >= 32'd4096) ? cur_kend - 32'd4096 : cur_top;
            1:       a = cur_top;
            default: a = cur_base + 32'h0800_0000;
          endcase
        end else begin
          a = allow_double ? last_free : $urandom;
        end
        issue_request(CMD_FREE, who, a, steady);
      end else begin
        issue_request(CMD_ALLOC, who, $urandom, steady);
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    cmd          <= CMD_ALLOC;
    cpu_id       <= '0;
    page_address <= '0;
    wr_en        <= 1'b0;
    wr_index     <= REG_MEMORY_BASE;
    wr_data      <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default layout: every list empty, then push, pop, steal and reject
    issue_request(CMD_ALLOC, 3'd0, 32'hFFFF_FFFF, 1'b0);
    issue_request(CMD_FREE,  3'd3, 32'h8000_0000, 1'b0);
    issue_request(CMD_FREE,  3'd3, 32'h87FF_F000, 1'b0);
    issue_request(CMD_ALLOC, 3'd3, 32'h0000_0000, 1'b0);
    issue_request(CMD_FREE,  3'd7, 32'h8000_1000, 1'b1);
    issue_request(CMD_FREE,  3'd5, 32'h8000_2000, 1'b1);
    issue_request(CMD_ALLOC, 3'd6, 32'h0000_0000, 1'b1);
    issue_request(CMD_ALLOC, 3'd6, 32'h0000_0000, 1'b0);
    issue_request(CMD_ALLOC, 3'd0, 32'h0000_0000, 1'b0);
    issue_request(CMD_ALLOC, 3'd2, 32'h0000_0000, 1'b0);
    issue_request(CMD_FREE,  3'd1, 32'h8000_0800, 1'b0);
    issue_request(CMD_FREE,  3'd1, 32'h7FFF_F000, 1'b0);
    issue_request(CMD_FREE,  3'd1, 32'h8800_0000, 1'b0);
    issue_request(CMD_FREE,  3'd1, 32'h0000_0000, 1'b0);
    issue_request(CMD_FREE,  3'd1, 32'hFFFF_FFFF, 1'b0);
    // same page freed on two cpus: the lists share it
    issue_request(CMD_FREE,  3'd1, 32'h8000_4000, 1'b1);
    issue_request(CMD_FREE,  3'd2, 32'h8000_4000, 1'b1);
    issue_request(CMD_ALLOC, 3'd1, 32'h0000_0000, 1'b1);
    issue_request(CMD_ALLOC, 3'd1, 32'h0000_0000, 1'b0);
    issue_request(CMD_ALLOC, 3'd1, 32'h0000_0000, 1'b0);

    run_phase(480, 16, 4000, 1'b0);
    load_layout(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    run_phase(450, 4096, 4096, 1'b0);
    // only the base page is valid here; older pages come back with wrapped addresses
    load_layout(32'hFFFF_F000, 32'h0000_0000, 32'hFFFF_FFFF);
    issue_request(CMD_FREE, 3'd4, 32'hFFFF_F000, 1'b0);
    run_phase(150, 8192, 4096, 1'b0);
    load_layout(32'h4000_0800, 32'h4000_0000, 32'h5000_0000);
    run_phase(150, 8192, 4096, 1'b0);
    load_layout(32'h1000_0000, 32'h1300_0000, 32'h1400_0000);
    run_phase(350, 12288, 4096, 1'b0);
    load_layout(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    run_phase(100, 16384, 4096, 1'b0);
    load_layout(32'hF800_0000, 32'hF800_0000, 32'hFFFF_FFFF);
    run_phase(350, 16384, 8192, 1'b1);
    wait_drained();

    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
